// ----- src/ps2_mouse_packet_cursor_core_macros.svh -----
// assertion macros shared by the ps2 mouse packet cursor core
`ifndef PS2_MOUSE_PACKET_CURSOR_CORE_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_CORE_MACROS_SVH

// check on every clock edge outside reset
`define PS2MC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define PS2MC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/ps2mc_pkg.sv -----
// shared types, constants and codes of the ps2 mouse packet cursor core
`default_nettype none

package ps2mc_pkg;

  // sizes
  localparam int POSITION_BITS = 12;
  localparam int TEXT_COLUMNS  = 80;
  localparam int FIRST_ROW     = 3;
  localparam int LAST_ROW      = 23;
  localparam int ACCUM_BITS    = 24;
  localparam int FAST_DELTA    = 6;
  localparam int QUEUE_DEPTH   = 2;

  // field widths fixed by the interface
  localparam int SIZE_BITS     = 12;
  localparam int PIX_OUT_BITS  = 12;
  localparam int DELTA_BITS    = 9;
  localparam int STEP_BITS     = 9;
  localparam int BTN_BITS      = 3;
  localparam int COL_OUT_BITS  = 7;
  localparam int ROW_OUT_BITS  = 5;
  localparam int REL_BITS      = 24;
  localparam int IN_DATA_BITS  = 16;
  localparam int OUT_DATA_BITS = 112;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;

  // derived widths
  localparam int COL_BITS      = $clog2(TEXT_COLUMNS);
  localparam int ROW_BITS      = $clog2(LAST_ROW + 1);
  localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GUI_MODE      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAPTURE_MODE  = 2'd3;

  // controller status and packet header bits
  localparam int STATUS_DATA_BIT = 0;
  localparam int HDR_SYNC_BIT    = 3;
  localparam int HDR_XSIGN_BIT   = 4;
  localparam int HDR_YSIGN_BIT   = 5;
  localparam int HDR_XOVF_BIT    = 6;
  localparam int HDR_YOVF_BIT    = 7;

  // what the back end does with a queued job
  typedef enum logic [1:0] {
    JOB_SHOW   = 2'd0,
    JOB_TAKE   = 2'd1,
    JOB_PACKET = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e                    kind;
    logic [BTN_BITS-1:0]          buttons;
    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
  } job_t;

  // result beat, last member in the lowest bits
  typedef struct packed {
    logic signed [REL_BITS-1:0]  rel_dy;
    logic signed [REL_BITS-1:0]  rel_dx;
    logic                        text_moved;
    logic [ROW_OUT_BITS-1:0]     text_row;
    logic [COL_OUT_BITS-1:0]     text_col;
    logic [BTN_BITS-1:0]         button_bits;
    logic signed [STEP_BITS-1:0] step_dy;
    logic signed [STEP_BITS-1:0] step_dx;
    logic [PIX_OUT_BITS-1:0]     cursor_y;
    logic [PIX_OUT_BITS-1:0]     cursor_x;
    logic                        event_valid;
    logic                        packet_done;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);

endpackage

`default_nettype wire

// ----- src/ps2mc_front.sv -----
// front end: takes controller beats, frames three-byte packets, emits jobs
`default_nettype none

module ps2mc_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                accept_i,
  input  wire logic                                cmd_i,
  input  wire logic [7:0]                          status_i,
  input  wire logic [7:0]                          data_i,
  output ps2mc_pkg::job_t                          job_o
);

  // framing state codes
  localparam logic [1:0] FRAME_HEADER = 2'd0;
  localparam logic [1:0] FRAME_X      = 2'd1;
  localparam logic [1:0] FRAME_Y      = 2'd2;

  logic [1:0] frame_q, frame_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] xb_q, xb_d;

  // classify the beat and advance the framing
  always_comb begin
    frame_d      = frame_q;
    hdr_d        = hdr_q;
    xb_d         = xb_q;
    job_o.kind    = ps2mc_pkg::JOB_SHOW;
    job_o.buttons = '0;
    job_o.dx      = '0;
    job_o.dy      = '0;
    if (cmd_i) begin
      job_o.kind = ps2mc_pkg::JOB_TAKE;
    end else if (status_i[ps2mc_pkg::STATUS_DATA_BIT]) begin
      unique case (frame_q)
        FRAME_HEADER: begin
          if (data_i[ps2mc_pkg::HDR_SYNC_BIT]) begin
            hdr_d   = data_i;
            frame_d = FRAME_X;
          end
        end
        FRAME_X: begin
          xb_d    = data_i;
          frame_d = FRAME_Y;
        end
        default: begin
          // third byte, and the unused code behaves the same
          frame_d = FRAME_HEADER;
          if (!hdr_q[ps2mc_pkg::HDR_XOVF_BIT] && !hdr_q[ps2mc_pkg::HDR_YOVF_BIT]) begin
            job_o.kind    = ps2mc_pkg::JOB_PACKET;
            job_o.buttons = hdr_q[ps2mc_pkg::BTN_BITS-1:0];
            job_o.dx      = {hdr_q[ps2mc_pkg::HDR_XSIGN_BIT], xb_q};
            job_o.dy      = {hdr_q[ps2mc_pkg::HDR_YSIGN_BIT], data_i};
          end
        end
      endcase
    end
  end

  // framing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= FRAME_HEADER;
      hdr_q   <= '0;
      xb_q    <= '0;
    end else if (accept_i) begin
      frame_q <= frame_d;
      hdr_q   <= hdr_d;
      xb_q    <= xb_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/ps2mc_queue.sv -----
// short job queue between the front and back ends
`default_nettype none

module ps2mc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ps2mc_pkg::job_t push_job_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output ps2mc_pkg::job_t      head_o
);

  localparam int Depth = ps2mc_pkg::QUEUE_DEPTH;

  ps2mc_pkg::job_t                      slot_q [Depth];
  logic [ps2mc_pkg::QPTR_BITS-1:0]      wr_ptr_q, rd_ptr_q;
  logic [ps2mc_pkg::QCNT_BITS-1:0]      count_q;

  assign full_o  = (count_q == ps2mc_pkg::QCNT_BITS'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // pointer wrap
  function automatic logic [ps2mc_pkg::QPTR_BITS-1:0] next_ptr(
    input logic [ps2mc_pkg::QPTR_BITS-1:0] p
  );
    logic [ps2mc_pkg::QPTR_BITS-1:0] r;
    if (p == ps2mc_pkg::QPTR_BITS'(Depth - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_job_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- src/ps2mc_back.sv -----
// back end: cursors, acceleration, accumulators and the result register
`default_nettype none

module ps2mc_back (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [ps2mc_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  wire logic [ps2mc_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  input  wire logic                                    job_valid_i,
  input  wire ps2mc_pkg::job_t                         job_i,
  output logic                                         job_pop_o,
  output logic                                         res_valid_o,
  input  wire logic                                    res_ready_i,
  output ps2mc_pkg::result_t                           res_o
);

  localparam int PosBits  = ps2mc_pkg::POSITION_BITS;
  localparam int SumBits  = ((PosBits > ps2mc_pkg::SIZE_BITS) ? PosBits
                              : ps2mc_pkg::SIZE_BITS) + 2;
  localparam int AccBits  = ps2mc_pkg::ACCUM_BITS;
  localparam int DBits    = ps2mc_pkg::DELTA_BITS;
  localparam int FastBits = DBits + 1;
  localparam int ColBits  = ps2mc_pkg::COL_BITS;
  localparam int RowBits  = ps2mc_pkg::ROW_BITS;
  localparam int StepBits = ps2mc_pkg::STEP_BITS;
  localparam int TxtBits0 = (ColBits > RowBits) ? ColBits : RowBits;
  localparam int TxtBits  = ((TxtBits0 > StepBits) ? TxtBits0 : StepBits) + 2;
  localparam int Div3Mul  = 683;
  localparam int Div3Sh   = 11;
  localparam int ProdBits = FastBits + 10;

  localparam logic signed [SumBits-1:0] PixMax  = SumBits'((1 << PosBits) - 1);
  localparam logic signed [TxtBits-1:0] ColMax  = TxtBits'(ps2mc_pkg::TEXT_COLUMNS - 1);
  localparam logic signed [TxtBits-1:0] RowMin  = TxtBits'(ps2mc_pkg::FIRST_ROW);
  localparam logic signed [TxtBits-1:0] RowMax  = TxtBits'(ps2mc_pkg::LAST_ROW);
  localparam logic signed [AccBits-1:0] AccMax  = {1'b0, {(AccBits-1){1'b1}}};
  localparam logic signed [AccBits-1:0] AccMin  = {1'b1, {(AccBits-1){1'b0}}};

  // configuration
  logic [ps2mc_pkg::SIZE_BITS-1:0] width_q, height_q;
  logic                            gui_q, capture_q;

  // cursor and accumulator state
  logic [PosBits-1:0]        pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic [ColBits-1:0]        col_q, col_d;
  logic [RowBits-1:0]        row_q, row_d;
  logic [ps2mc_pkg::BTN_BITS-1:0] btn_q, btn_d;
  logic signed [AccBits-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;

  // result register
  logic                      out_valid_q;
  ps2mc_pkg::result_t        out_q, res_d;

  // datapath
  logic [DBits-1:0]          abs_x, abs_y;
  logic                      fast;
  logic signed [FastBits-1:0] mx, my;
  logic [FastBits-1:0]       mag_x, mag_y;
  logic [ProdBits-1:0]       prod_x, prod_y;
  logic [StepBits-1:0]       quo_x, quo_y;
  logic signed [StepBits-1:0] sdx, sdy;
  logic signed [SumBits-1:0] px_sum, py_sum;
  logic signed [TxtBits-1:0] col_sum, row_sum;
  logic signed [AccBits:0]   accx_sum, accy_sum;

  assign job_pop_o   = job_valid_i && (!out_valid_q || res_ready_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // clamp a moved pixel position to the screen
  function automatic logic [PosBits-1:0] clamp_pixel(
    input logic signed [SumBits-1:0]           v,
    input logic [ps2mc_pkg::SIZE_BITS-1:0]     size
  );
    logic signed [SumBits-1:0] t;
    logic signed [SumBits-1:0] sz;
    t  = v;
    sz = $signed(SumBits'(size));
    if (t < 0) t = '0;
    if ((size != '0) && (t >= sz)) t = sz - SumBits'(1);
    if (t > PixMax) t = PixMax;
    return PosBits'(t);
  endfunction

  // saturate an accumulator sum
  function automatic logic signed [AccBits-1:0] sat_acc(input logic signed [AccBits:0] v);
    logic signed [AccBits-1:0] r;
    if (v[AccBits] != v[AccBits-1]) r = v[AccBits] ? AccMin : AccMax;
    else r = v[AccBits-1:0];
    return r;
  endfunction

  // acceleration: double both deltas when either is fast
  always_comb begin
    abs_x = job_i.dx[DBits-1] ? DBits'(-job_i.dx) : DBits'(job_i.dx);
    abs_y = job_i.dy[DBits-1] ? DBits'(-job_i.dy) : DBits'(job_i.dy);
    fast  = (abs_x >= DBits'(ps2mc_pkg::FAST_DELTA)) ||
            (abs_y >= DBits'(ps2mc_pkg::FAST_DELTA));
    mx    = fast ? {job_i.dx, 1'b0} : FastBits'(job_i.dx);
    my    = fast ? {job_i.dy, 1'b0} : FastBits'(job_i.dy);
  end

  // divide by three toward zero through a reciprocal multiply
  always_comb begin
    mag_x  = mx[FastBits-1] ? FastBits'(-mx) : FastBits'(mx);
    mag_y  = my[FastBits-1] ? FastBits'(-my) : FastBits'(my);
    prod_x = ProdBits'(mag_x) * ProdBits'(Div3Mul);
    prod_y = ProdBits'(mag_y) * ProdBits'(Div3Mul);
    quo_x  = prod_x[Div3Sh +: StepBits];
    quo_y  = prod_y[Div3Sh +: StepBits];
    sdx    = mx[FastBits-1] ? $signed(~quo_x + 1'b1) : $signed(quo_x);
    sdy    = my[FastBits-1] ? $signed(~quo_y + 1'b1) : $signed(quo_y);
  end

  // sums for the cursors and accumulators
  always_comb begin
    px_sum   = $signed(SumBits'(pix_x_q)) + SumBits'(mx);
    py_sum   = $signed(SumBits'(pix_y_q)) - SumBits'(my);
    col_sum  = $signed(TxtBits'(col_q)) + TxtBits'(sdx);
    row_sum  = $signed(TxtBits'(row_q)) - TxtBits'(sdy);
    accx_sum = (AccBits+1)'(acc_x_q) + (AccBits+1)'(job_i.dx);
    accy_sum = (AccBits+1)'(acc_y_q) + (AccBits+1)'(job_i.dy);
  end

  // carry out the job
  always_comb begin
    pix_x_d = pix_x_q;
    pix_y_d = pix_y_q;
    col_d   = col_q;
    row_d   = row_q;
    btn_d   = btn_q;
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    res_d   = '0;
    unique case (job_i.kind)
      ps2mc_pkg::JOB_TAKE: begin
        res_d.rel_dx = ps2mc_pkg::REL_BITS'(acc_x_q);
        res_d.rel_dy = ps2mc_pkg::REL_BITS'(acc_y_q);
        acc_x_d      = '0;
        acc_y_d      = '0;
      end
      ps2mc_pkg::JOB_PACKET: begin
        res_d.packet_done = 1'b1;
        btn_d             = job_i.buttons;
        if (capture_q) begin
          acc_x_d = sat_acc(accx_sum);
          acc_y_d = sat_acc(accy_sum);
        end else begin
          pix_x_d       = clamp_pixel(px_sum, width_q);
          pix_y_d       = clamp_pixel(py_sum, height_q);
          res_d.step_dx = sdx;
          res_d.step_dy = sdy;
          if (gui_q) begin
            res_d.event_valid = 1'b1;
          end else begin
            if (col_sum < 0)           col_d = '0;
            else if (col_sum > ColMax) col_d = ColBits'(ColMax);
            else                       col_d = ColBits'(col_sum);
            if (row_sum < RowMin)      row_d = RowBits'(RowMin);
            else if (row_sum > RowMax) row_d = RowBits'(RowMax);
            else                       row_d = RowBits'(row_sum);
            res_d.text_moved = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res_d.cursor_x    = ps2mc_pkg::PIX_OUT_BITS'(pix_x_d);
    res_d.cursor_y    = ps2mc_pkg::PIX_OUT_BITS'(pix_y_d);
    res_d.button_bits = btn_d;
    res_d.text_col    = ps2mc_pkg::COL_OUT_BITS'(col_d);
    res_d.text_row    = ps2mc_pkg::ROW_OUT_BITS'(row_d);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= ps2mc_pkg::SIZE_BITS'(800);
      height_q  <= ps2mc_pkg::SIZE_BITS'(600);
      gui_q     <= 1'b0;
      capture_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ps2mc_pkg::REG_SCREEN_WIDTH:  width_q   <= cfg_data_i;
        ps2mc_pkg::REG_SCREEN_HEIGHT: height_q  <= cfg_data_i;
        ps2mc_pkg::REG_GUI_MODE:      gui_q     <= cfg_data_i[0];
        ps2mc_pkg::REG_CAPTURE_MODE:  capture_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // cursor state and accumulators; a capture mode write clears the latter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_x_q <= PosBits'(400);
      pix_y_q <= PosBits'(300);
      col_q   <= ColBits'(40);
      row_q   <= RowBits'(12);
      btn_q   <= '0;
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == ps2mc_pkg::REG_CAPTURE_MODE)) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (job_pop_o) begin
      pix_x_q <= pix_x_d;
      pix_y_q <= pix_y_d;
      col_q   <= col_d;
      row_q   <= row_d;
      btn_q   <= btn_d;
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
    end
  end

  // result beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (job_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (job_pop_o) out_q <= res_d;
  end

endmodule

`default_nettype wire

// ----- src/ps2_mouse_packet_cursor_core.sv -----
// top level of the ps2 mouse packet cursor core
`default_nettype none

// Each input beat (a controller byte with its status, or a take command)
// gives exactly one result beat. One beat is taken every clock cycle while
// the queue is not full; the front end frames the three-byte packets and
// hands jobs to a two-entry queue, and the back end applies one job per cycle
// to the cursors and accumulators while the output register is empty or read.
// A beat's job is registered in the queue, then its result in the output
// register, and the input keeps flowing while a result waits there until the queue is full.
// The rate is set by the back-end cursor update. Configuration writes belong to times when no beat is in flight.
module ps2_mouse_packet_cursor_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration writes
  input  wire logic                                cfg_we_i,
  input  wire logic [ps2mc_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [ps2mc_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  // input beats
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // ctrl_status[7:0], data_byte[15:8]
  input  wire logic [ps2mc_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // cmd
  input  wire logic                                s_axis_tuser,
  // result beats
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // packet_done[0], event_valid[1], cursor_x[13:2], cursor_y[25:14],
  // step_dx[34:26], step_dy[43:35], button_bits[46:44], text_col[53:47],
  // text_row[58:54], text_moved[59], rel_dx[83:60], rel_dy[107:84], zero pad
  output logic [ps2mc_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata
);

  logic               in_accept;
  logic               q_full, q_valid, q_pop;
  ps2mc_pkg::job_t    front_job, head_job;
  ps2mc_pkg::result_t res;

  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = ps2mc_pkg::OUT_DATA_BITS'(res);

  // framing and classification
  ps2mc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .cmd_i    (s_axis_tuser),
    .status_i (s_axis_tdata[7:0]),
    .data_i   (s_axis_tdata[15:8]),
    .job_o    (front_job)
  );

  // job queue
  ps2mc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_accept),
    .push_job_i (front_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  // cursor update and result register
  ps2mc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .job_pop_o   (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  `include "ps2_mouse_packet_cursor_core_macros.svh"

  // no result beat can be pending while reset is held
  `PS2MC_ASSERT_ALWAYS(a_no_beat_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid, "result valid in reset")
  // text cursor stays inside the text window
  `PS2MC_ASSERT(a_text_range, clk_i, rst_ni, m_axis_tvalid |-> (res.text_row >= ps2mc_pkg::ROW_OUT_BITS'(ps2mc_pkg::FIRST_ROW)) && (res.text_row <= ps2mc_pkg::ROW_OUT_BITS'(ps2mc_pkg::LAST_ROW)) && (res.text_col <= ps2mc_pkg::COL_OUT_BITS'(ps2mc_pkg::TEXT_COLUMNS - 1)), "text cursor out of range")
  // a pointer event or a text move only comes with a finished packet, never both
  `PS2MC_ASSERT(a_event_needs_packet, clk_i, rst_ni, m_axis_tvalid && (res.event_valid || res.text_moved) |-> res.packet_done && !(res.event_valid && res.text_moved), "event without packet")
  // a take never completes a packet
  `PS2MC_ASSERT(a_take_no_packet, clk_i, rst_ni, m_axis_tvalid && res.packet_done |-> (res.rel_dx == '0) && (res.rel_dy == '0), "packet beat carries relative deltas")

endmodule

`default_nettype wire
